FILE: rtl/core/usbpp_pkg.sv
// shared types and codes for the usb ping-pong endpoint transfer engine
`default_nettype none
package usbpp_pkg;

   // operation codes
   localparam logic [1:0] OP_START    = 2'd0;
   localparam logic [1:0] OP_COMPLETE = 2'd1;
   localparam logic [1:0] OP_STOP     = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_REJECTED = 3'd0;
   localparam logic [2:0] STAT_ARMED    = 3'd1;
   localparam logic [2:0] STAT_PROGRESS = 3'd2;
   localparam logic [2:0] STAT_DONE     = 3'd3;
   localparam logic [2:0] STAT_STOPPED  = 3'd4;

   // configuration register indexes
   localparam int         CSR_IDX_W      = 1;
   localparam int         CSR_DATA_W     = 10;
   localparam logic [0:0] CSR_MAX_PACKET = 1'b0;
   localparam logic [0:0] CSR_OPTIONS    = 1'b1;

   typedef struct packed {
      logic [2:0]  status;
      logic        arm_valid;
      logic        arm_odd;
      logic [31:0] arm_addr;
      logic [9:0]  arm_len;
      logic [6:0]  arm_ctrl;
      logic [15:0] total_count;
      logic        is_stalled;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type item0;
      rsp_item_type item1;
      logic         has_two;
   } rsp_pair_type;

endpackage
`default_nettype wire

FILE: rtl/core/usb_pingpong_endpoint_transfer.sv
// top level of the usb ping-pong endpoint transfer engine
`default_nettype none
// Splits an endpoint transfer into max-packet chunks handed out over the even
// and odd buffer descriptors. Every item is processed in the cycle it is
// accepted; its results enter a queue of RSP_DEPTH entries and appear on the
// rsp_ channel from the next cycle on, one result per cycle while rsp_ready
// is high. A start that arms two descriptors yields two results, every other
// item one. The request side takes a new item each cycle while the queue has
// room for two results, so with rsp_ready high the sustained rate is one item
// per cycle for single-result items and set by the one-result-per-cycle output
// port otherwise. Configuration (csr_index 0 max packet, 1 option bits) must
// be written only while no item is outstanding; the block does not enforce it.
module usb_pingpong_endpoint_transfer #(
   parameter int RSP_DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_operation,
   input  wire logic [31:0]                        req_buf_addr,
   input  wire logic [15:0]                        req_byte_count,
   input  wire logic                               req_data01,
   input  wire logic                               req_stall_req,
   input  wire logic                               req_odd_done,
   input  wire logic [9:0]                         req_done_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_status,
   output logic                                    rsp_arm_valid,
   output logic                                    rsp_arm_odd,
   output logic [31:0]                             rsp_arm_addr,
   output logic [9:0]                              rsp_arm_len,
   output logic [6:0]                              rsp_arm_ctrl,
   output logic [15:0]                             rsp_total_count,
   output logic                                    rsp_is_stalled,
   output logic                                    rsp_last,
   input  wire logic                               csr_wr_en,
   input  wire logic [usbpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [usbpp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import usbpp_pkg::*;

   rsp_pair_type pair;
   rsp_item_type head;
   logic         accept;

   assign accept = req_valid && req_ready;

   usbpp_xfer_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_operation  (req_operation),
      .req_buf_addr   (req_buf_addr),
      .req_byte_count (req_byte_count),
      .req_data01     (req_data01),
      .req_stall_req  (req_stall_req),
      .req_odd_done   (req_odd_done),
      .req_done_count (req_done_count),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pair           (pair)
   );

   usbpp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .pair      (pair),
      .space_ok  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head)
   );

   assign rsp_status      = head.status;
   assign rsp_arm_valid   = head.arm_valid;
   assign rsp_arm_odd     = head.arm_odd;
   assign rsp_arm_addr    = head.arm_addr;
   assign rsp_arm_len     = head.arm_len;
   assign rsp_arm_ctrl    = head.arm_ctrl;
   assign rsp_total_count = head.total_count;
   assign rsp_is_stalled  = head.is_stalled;
   assign rsp_last        = head.last;

endmodule
`default_nettype wire

FILE: rtl/core/usbpp_xfer_core.sv
// descriptor state, configuration registers and per-item result computation
`default_nettype none
module usbpp_xfer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [1:0]                         req_operation,
   input  wire logic [31:0]                        req_buf_addr,
   input  wire logic [15:0]                        req_byte_count,
   input  wire logic                               req_data01,
   input  wire logic                               req_stall_req,
   input  wire logic                               req_odd_done,
   input  wire logic [9:0]                         req_done_count,
   input  wire logic                               csr_wr_en,
   input  wire logic [usbpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [usbpp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output usbpp_pkg::rsp_pair_type                 pair
);
   import usbpp_pkg::*;

   logic [9:0]  max_packet_ff;
   logic [2:0]  options_ff;
   logic [1:0]  owned_ff, owned_in;
   logic [1:0]  stall_ff, stall_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [1:0]  bufs_ff, bufs_in;
   logic        next_odd_ff, next_odd_in;
   logic        toggle_ff, toggle_in;
   logic [15:0] requested_ff, requested_in;
   logic [15:0] transferred_ff, transferred_in;

   logic [15:0] mp16;
   logic        start_ok;
   logic        len_over;
   logic [15:0] rest;
   logic [9:0]  n1, n2;
   logic [31:0] addr2, addr_end;
   logic [15:0] tr_sum, rem;
   logic [1:0]  bufs_dec;
   logic        xfer_done;
   logic [9:0]  clen;
   logic        odd_a;
   logic        stall_after;
   rsp_pair_type res;

   assign mp16     = {6'd0, max_packet_ff};
   assign start_ok = (bufs_ff == 2'd0) && (max_packet_ff != 10'd0)
                     && !(|(owned_ff & stall_ff));

   // start: split into up to two chunks
   assign len_over = req_byte_count > mp16;
   assign rest     = req_byte_count - mp16;
   assign n1       = len_over ? max_packet_ff : req_byte_count[9:0];
   assign n2       = !len_over ? 10'd0 : ((rest > mp16) ? max_packet_ff : rest[9:0]);
   assign addr2    = req_buf_addr + {22'd0, n1};
   assign addr_end = addr2 + {22'd0, n2};

   // completion: add count and decide on re-arm
   assign tr_sum    = transferred_ff + {6'd0, req_done_count};
   assign bufs_dec  = (bufs_ff != 2'd0) ? bufs_ff - 2'd1 : 2'd0;
   assign xfer_done = (tr_sum >= requested_ff) || (req_done_count < max_packet_ff);
   assign rem       = requested_ff - tr_sum;
   assign clen      = (rem > mp16) ? max_packet_ff : rem[9:0];
   assign odd_a     = next_odd_ff;

   always_comb begin
      owned_in       = owned_ff;
      stall_in       = stall_ff;
      next_addr_in   = next_addr_ff;
      bufs_in        = bufs_ff;
      next_odd_in    = next_odd_ff;
      toggle_in      = toggle_ff;
      requested_in   = requested_ff;
      transferred_in = transferred_ff;
      res            = '0;
      res.item0.status = STAT_REJECTED;
      unique case (req_operation)
         OP_START: begin
            if (start_ok) begin
               requested_in   = req_byte_count;
               transferred_in = 16'd0;
               res.item0.status    = STAT_ARMED;
               res.item0.arm_valid = 1'b1;
               res.item0.arm_odd   = next_odd_ff;
               res.item0.arm_addr  = req_buf_addr;
               res.item0.arm_len   = n1;
               res.item0.arm_ctrl  = {req_data01, options_ff, req_stall_req, 2'b00};
               owned_in[next_odd_ff] = 1'b1;
               stall_in[next_odd_ff] = req_stall_req;
               if ((n2 != 10'd0) && !req_stall_req) begin
                  res.has_two         = 1'b1;
                  res.item1.status    = STAT_ARMED;
                  res.item1.arm_valid = 1'b1;
                  res.item1.arm_odd   = ~next_odd_ff;
                  res.item1.arm_addr  = addr2;
                  res.item1.arm_len   = n2;
                  res.item1.arm_ctrl  = {~req_data01, options_ff, 3'b000};
                  owned_in[~next_odd_ff] = 1'b1;
                  stall_in[~next_odd_ff] = 1'b0;
                  next_addr_in = addr_end;
                  bufs_in      = 2'd2;
                  next_odd_in  = next_odd_ff;
                  toggle_in    = req_data01;
               end else begin
                  next_addr_in = addr2;
                  bufs_in      = 2'd1;
                  next_odd_in  = ~next_odd_ff;
                  toggle_in    = ~req_data01;
               end
            end
         end
         OP_COMPLETE: begin
            owned_in[req_odd_done] = 1'b0;
            transferred_in = tr_sum;
            if (xfer_done) begin
               bufs_in     = 2'd0;
               next_odd_in = ~req_odd_done;
               res.item0.status = STAT_DONE;
            end else begin
               res.item0.status    = STAT_PROGRESS;
               res.item0.arm_valid = 1'b1;
               res.item0.arm_odd   = odd_a;
               res.item0.arm_addr  = next_addr_ff;
               res.item0.arm_len   = clen;
               res.item0.arm_ctrl  = {toggle_ff, options_ff, 3'b000};
               owned_in[odd_a] = 1'b1;
               stall_in[odd_a] = 1'b0;
               next_addr_in = next_addr_ff + {22'd0, clen};
               bufs_in      = bufs_dec + 2'd1;
               next_odd_in  = ~odd_a;
               toggle_in    = ~toggle_ff;
            end
         end
         OP_STOP: begin
            // every released descriptor flips the parity
            next_odd_in = next_odd_ff ^ owned_ff[0] ^ owned_ff[1];
            owned_in    = 2'b00;
            res.item0.status = STAT_STOPPED;
         end
         default: begin
            res.item0.status = STAT_REJECTED;
         end
      endcase
      stall_after = |(owned_in & stall_in);
      res.item0.total_count = transferred_in;
      res.item1.total_count = transferred_in;
      res.item0.is_stalled  = stall_after;
      res.item1.is_stalled  = stall_after;
      res.item0.last        = !res.has_two;
      res.item1.last        = 1'b1;
   end

   assign pair = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff  <= '0;
         options_ff     <= '0;
         owned_ff       <= '0;
         stall_ff       <= '0;
         next_addr_ff   <= '0;
         bufs_ff        <= '0;
         next_odd_ff    <= 1'b0;
         toggle_ff      <= 1'b0;
         requested_ff   <= '0;
         transferred_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAX_PACKET: max_packet_ff <= csr_wdata;
               CSR_OPTIONS:    options_ff    <= csr_wdata[2:0];
               default:        ;
            endcase
         end
         if (accept) begin
            owned_ff       <= owned_in;
            stall_ff       <= stall_in;
            next_addr_ff   <= next_addr_in;
            bufs_ff        <= bufs_in;
            next_odd_ff    <= next_odd_in;
            toggle_ff      <= toggle_in;
            requested_ff   <= requested_in;
            transferred_ff <= transferred_in;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/usbpp_rsp_fifo.sv
// result queue taking one or two items per push and handing out one per cycle while out_ready is high
`default_nettype none
module usbpp_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire usbpp_pkg::rsp_pair_type pair,
   output logic                         space_ok,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output usbpp_pkg::rsp_item_type      out_item
);
   import usbpp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH - 2);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_nxt;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
   endfunction

   assign space_ok  = count_ff <= FILL_MAX;
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_nxt    = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = pair.has_two ? ptr_inc(wr_nxt) : wr_nxt;
         count_in  = count_ff + (pair.has_two ? CNT_W'(2) : CNT_W'(1));
      end
      if (pop) begin
         count_in = count_in - CNT_W'(1);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= pair.item0;
         if (pair.has_two) begin
            mem_ff[wr_nxt] <= pair.item1;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/usbpp_checker.sv
// port-level checks for the usb ping-pong endpoint transfer engine
`default_nettype none
module usbpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_arm_valid,
   input wire logic        rsp_arm_odd,
   input wire logic [31:0] rsp_arm_addr,
   input wire logic [9:0]  rsp_arm_len,
   input wire logic [6:0]  rsp_arm_ctrl,
   input wire logic        rsp_last
);
   import usbpp_pkg::*;

   // a waiting result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_arm_addr)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // descriptor fields are zero unless a descriptor is armed
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_arm_valid |-> !rsp_arm_odd && rsp_arm_addr == 32'd0
         && rsp_arm_len == 10'd0 && rsp_arm_ctrl == 7'd0)
      else $error("non-arming result carries descriptor data");

   // arming goes with the armed and in-progress codes only
   a_arm_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_arm_valid == (rsp_status == STAT_ARMED
         || rsp_status == STAT_PROGRESS))
      else $error("arm flag and status disagree");

   // a re-armed chunk never stalls and low ctrl bits stay clear
   a_rearm_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_PROGRESS |-> rsp_arm_ctrl[2:0] == 3'd0)
      else $error("re-armed descriptor has stall or reserved bits");

   // only a start with two chunks gives a result that is not last
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_ARMED |-> rsp_last)
      else $error("single-result item not marked last");

endmodule

bind usb_pingpong_endpoint_transfer usbpp_checker u_usbpp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_arm_valid (rsp_arm_valid),
   .rsp_arm_odd   (rsp_arm_odd),
   .rsp_arm_addr  (rsp_arm_addr),
   .rsp_arm_len   (rsp_arm_len),
   .rsp_arm_ctrl  (rsp_arm_ctrl),
   .rsp_last      (rsp_last)
);
`default_nettype wire
